// ===== hw/rtl/tcpmq_pkg.sv =====
// tcpmq_pkg: shared constants, widths and codes for the three-class priority multi-queue
`timescale 1ns / 1ps

package tcpmq_pkg;

    localparam int NUM_POINTS  = 8;
    localparam int CLASS_DEPTH = 16;
    localparam int NUM_CLASSES = 3;

    localparam int POINT_W  = 3;
    localparam int PRI_W    = 2;
    localparam int ID_W     = 37;
    localparam int CNT_W    = 10;
    localparam int STATUS_W = 2;
    localparam int MASK_W   = 8;

    localparam int HEAD_W    = $clog2(CLASS_DEPTH);
    localparam int FILL_W    = $clog2(CLASS_DEPTH + 1);
    localparam int PT_IDX_W  = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;
    localparam int NUM_FIFOS = NUM_POINTS * NUM_CLASSES;
    localparam int MEM_DEPTH = NUM_FIFOS * CLASS_DEPTH;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam int ENTRY_W   = ID_W + CNT_W;

    // input word: point, priority_req, customer_id, item_count from bit 0 up
    localparam int S_PT_LO  = 0;
    localparam int S_PRI_LO = S_PT_LO + POINT_W;
    localparam int S_ID_LO  = S_PRI_LO + PRI_W;
    localparam int S_CNT_LO = S_ID_LO + ID_W;
    localparam int S_USED_W = S_CNT_LO + CNT_W;
    localparam int S_TDATA_W = ((S_USED_W + 7) / 8) * 8;

    // result word: status, out_customer_id, out_item_count, out_priority
    localparam int M_USED_W  = STATUS_W + ID_W + CNT_W + PRI_W;
    localparam int M_TDATA_W = ((M_USED_W + 7) / 8) * 8;

    typedef enum logic [0:0] {
        OP_ENQ = 1'b0,
        OP_DEQ = 1'b1
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_CLOSED = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_FULL   = 2'd3
    } t_status;

endpackage

// ===== hw/rtl/three_class_priority_multi_queue.sv =====
// three_class_priority_multi_queue: per-point strict priority queues built from three class fifos
`timescale 1ns / 1ps

// Eight service points, each with three FIFOs (class 1 served first, FIFO order within a
// class), sharing one entry memory of NUM_POINTS*3*CLASS_DEPTH words. A word on the
// s_axis side is an enqueue (tuser 0) or a dequeue (tuser 1); each gives exactly one result
// word on m_axis carrying a status, and for a successful dequeue the removed id, count and
// class. Throughput is one word per clock while m_axis is not stalled. The first stage
// holds the accepted request word and does the head/fill read-modify-write of the addressed
// point plus the entry memory write or read; the second stage holds its result word, with
// the entry memory read data registered there. Stalls on m_axis back up through both
// stages. The open mask is written on the cfg channel, which is always ready, and must
// only change while no word is in flight. Entries are never read before written, so the
// memory needs no clearing after reset.
module three_class_priority_multi_queue (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration: open_mask
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [tcpmq_pkg::MASK_W-1:0]      i_cfg_data,
    // request words
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // point, priority_req, customer_id, item_count (from bit 0 up)
    input  logic [tcpmq_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    // operation
    input  logic                              s_axis_tuser,
    // result words
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // status, out_customer_id, out_item_count, out_priority (from bit 0 up)
    output logic [tcpmq_pkg::M_TDATA_W-1:0]   m_axis_tdata
);

    typedef logic [tcpmq_pkg::HEAD_W-1:0]   t_head;
    typedef logic [tcpmq_pkg::FILL_W-1:0]   t_fill;
    typedef logic [tcpmq_pkg::HEAD_W:0]     t_sum;
    typedef logic [tcpmq_pkg::ADDR_W-1:0]   t_addr;
    typedef logic [tcpmq_pkg::PT_IDX_W-1:0] t_pt_idx;
    typedef logic [1:0]                     t_cls;

    // configuration
    logic [tcpmq_pkg::MASK_W-1:0] r_open_mask;

    // queue pointers
    t_head r_head [tcpmq_pkg::NUM_POINTS][tcpmq_pkg::NUM_CLASSES];
    t_fill r_fill [tcpmq_pkg::NUM_POINTS][tcpmq_pkg::NUM_CLASSES];

    // entry memory
    logic [tcpmq_pkg::ENTRY_W-1:0] mem [tcpmq_pkg::MEM_DEPTH];
    logic [tcpmq_pkg::ENTRY_W-1:0] r_rd_q;

    // stage a: accepted word
    logic                          r_a_valid;
    tcpmq_pkg::t_op                r_a_op;
    logic [tcpmq_pkg::POINT_W-1:0] r_a_point;
    logic [tcpmq_pkg::PRI_W-1:0]   r_a_pri;
    logic [tcpmq_pkg::ID_W-1:0]    r_a_id;
    logic [tcpmq_pkg::CNT_W-1:0]   r_a_cnt;

    // stage b: result
    logic                          r_b_valid;
    tcpmq_pkg::t_status            r_b_status;
    logic [tcpmq_pkg::PRI_W-1:0]   r_b_pri;

    logic               b_advance;
    logic               a_fire;
    logic               s_fire;
    logic               a_open;
    t_pt_idx            a_idx;
    t_cls               a_cls_enq;
    t_cls               a_cls_deq;
    logic               a_found;
    t_head              a_head_enq;
    t_fill              a_fill_enq;
    t_head              a_head_deq;
    t_fill              a_fill_deq;
    logic               a_full;
    t_sum               a_tail_sum;
    t_head              a_tail;
    t_sum               a_head_sum;
    t_head              n_head;
    t_fill              n_fill_inc;
    t_fill              n_fill_dec;
    tcpmq_pkg::t_status a_status;
    logic [tcpmq_pkg::PRI_W-1:0] a_pri_out;
    logic               a_wr_en;
    logic               a_rd_en;
    logic               a_deq_ok;
    t_addr              a_wr_addr;
    t_addr              a_rd_addr;
    logic [tcpmq_pkg::ID_W-1:0]  b_id;
    logic [tcpmq_pkg::CNT_W-1:0] b_cnt;

    assign o_cfg_ready   = 1'b1;
    assign b_advance     = !r_b_valid || m_axis_tready;
    assign a_fire        = r_a_valid && b_advance;
    assign s_axis_tready = !r_a_valid || b_advance;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        a_idx  = t_pt_idx'(r_a_point);
        a_open = (int'(r_a_point) < tcpmq_pkg::NUM_POINTS) && r_open_mask[r_a_point];

        // priority zero is stored as class 1
        a_cls_enq = (r_a_pri == '0) ? t_cls'(0) : t_cls'(r_a_pri - 2'd1);

        a_found   = 1'b1;
        a_cls_deq = t_cls'(0);
        if (r_fill[a_idx][0] != '0) begin
            a_cls_deq = t_cls'(0);
        end else if (r_fill[a_idx][1] != '0) begin
            a_cls_deq = t_cls'(1);
        end else if (r_fill[a_idx][2] != '0) begin
            a_cls_deq = t_cls'(2);
        end else begin
            a_found = 1'b0;
        end

        a_head_enq = r_head[a_idx][a_cls_enq];
        a_fill_enq = r_fill[a_idx][a_cls_enq];
        a_head_deq = r_head[a_idx][a_cls_deq];
        a_fill_deq = r_fill[a_idx][a_cls_deq];
        a_full     = (a_fill_enq == t_fill'(tcpmq_pkg::CLASS_DEPTH));

        a_tail_sum = {1'b0, a_head_enq} + t_sum'(a_fill_enq);
        if (a_tail_sum >= t_sum'(tcpmq_pkg::CLASS_DEPTH)) begin
            a_tail_sum = a_tail_sum - t_sum'(tcpmq_pkg::CLASS_DEPTH);
        end
        a_tail = a_tail_sum[tcpmq_pkg::HEAD_W-1:0];

        a_head_sum = {1'b0, a_head_deq} + t_sum'(1);
        if (a_head_sum >= t_sum'(tcpmq_pkg::CLASS_DEPTH)) begin
            a_head_sum = a_head_sum - t_sum'(tcpmq_pkg::CLASS_DEPTH);
        end
        n_head     = a_head_sum[tcpmq_pkg::HEAD_W-1:0];
        n_fill_inc = a_fill_enq + t_fill'(1);
        n_fill_dec = a_fill_deq - t_fill'(1);

        a_pri_out = '0;
        if (!a_open) begin
            a_status = tcpmq_pkg::ST_CLOSED;
        end else if (r_a_op == tcpmq_pkg::OP_ENQ) begin
            a_status = a_full ? tcpmq_pkg::ST_FULL : tcpmq_pkg::ST_OK;
        end else if (a_found) begin
            a_status  = tcpmq_pkg::ST_OK;
            a_pri_out = tcpmq_pkg::PRI_W'(a_cls_deq) + tcpmq_pkg::PRI_W'(1);
        end else begin
            a_status = tcpmq_pkg::ST_EMPTY;
        end

        a_deq_ok = a_open && (r_a_op == tcpmq_pkg::OP_DEQ) && a_found;
        a_wr_en  = a_fire && a_open && (r_a_op == tcpmq_pkg::OP_ENQ) && !a_full;
        a_rd_en  = a_fire && a_deq_ok;

        a_wr_addr = t_addr'(a_idx) * t_addr'(tcpmq_pkg::NUM_CLASSES * tcpmq_pkg::CLASS_DEPTH)
                  + t_addr'(a_cls_enq) * t_addr'(tcpmq_pkg::CLASS_DEPTH) + t_addr'(a_tail);
        a_rd_addr = t_addr'(a_idx) * t_addr'(tcpmq_pkg::NUM_CLASSES * tcpmq_pkg::CLASS_DEPTH)
                  + t_addr'(a_cls_deq) * t_addr'(tcpmq_pkg::CLASS_DEPTH) + t_addr'(a_head_deq);
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_mask <= '0;
            r_a_valid   <= 1'b0;
            r_b_valid   <= 1'b0;
            for (int p = 0; p < tcpmq_pkg::NUM_POINTS; p++) begin
                for (int c = 0; c < tcpmq_pkg::NUM_CLASSES; c++) begin
                    r_head[p][c] <= '0;
                    r_fill[p][c] <= '0;
                end
            end
        end else begin
            if (i_cfg_valid) begin
                r_open_mask <= i_cfg_data;
            end
            if (s_axis_tready) begin
                r_a_valid <= s_axis_tvalid;
            end
            if (b_advance) begin
                r_b_valid <= r_a_valid;
            end
            if (a_wr_en) begin
                r_fill[a_idx][a_cls_enq] <= n_fill_inc;
            end
            if (a_rd_en) begin
                r_head[a_idx][a_cls_deq] <= n_head;
                r_fill[a_idx][a_cls_deq] <= n_fill_dec;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_fire) begin
            r_a_op    <= tcpmq_pkg::t_op'(s_axis_tuser);
            r_a_point <= s_axis_tdata[tcpmq_pkg::S_PT_LO +: tcpmq_pkg::POINT_W];
            r_a_pri   <= s_axis_tdata[tcpmq_pkg::S_PRI_LO +: tcpmq_pkg::PRI_W];
            r_a_id    <= s_axis_tdata[tcpmq_pkg::S_ID_LO +: tcpmq_pkg::ID_W];
            r_a_cnt   <= s_axis_tdata[tcpmq_pkg::S_CNT_LO +: tcpmq_pkg::CNT_W];
        end
        if (a_fire) begin
            r_b_status <= a_status;
            r_b_pri    <= a_pri_out;
        end
    end

    // entry memory, read data held until the next dequeue moves on
    always_ff @(posedge i_clk) begin
        if (a_wr_en) begin
            mem[a_wr_addr] <= {r_a_cnt, r_a_id};
        end
        if (a_rd_en) begin
            r_rd_q <= mem[a_rd_addr];
        end
    end

    // nonzero class marks a successful dequeue
    assign b_id  = (r_b_pri != '0) ? r_rd_q[tcpmq_pkg::ID_W-1:0] : '0;
    assign b_cnt = (r_b_pri != '0) ? r_rd_q[tcpmq_pkg::ENTRY_W-1:tcpmq_pkg::ID_W] : '0;

    assign m_axis_tvalid = r_b_valid;
    assign m_axis_tdata  = tcpmq_pkg::M_TDATA_W'({r_b_pri, b_cnt, b_id, r_b_status});

`ifndef ASSERT_OFF
    a_deq_reaches_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        a_rd_en |=> r_b_valid && r_b_status == tcpmq_pkg::ST_OK && r_b_pri != '0)
        else $error("successful dequeue did not reach the result stage");

    a_fail_has_no_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_valid && r_b_status != tcpmq_pkg::ST_OK |-> r_b_pri == '0)
        else $error("failed request carries a class");

    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> r_a_valid && r_b_valid && !m_axis_tready)
        else $error("input stalled with room in the pipeline");
`endif

endmodule

// ===== tb/three_class_priority_multi_queue_tb.sv =====
// three_class_priority_multi_queue_tb: self-checking regression for the three-class priority multi-queue
`timescale 1ns / 1ps

module three_class_priority_multi_queue_tb;
    import tcpmq_pkg::*;

    localparam logic [ID_W-1:0] ID_MAX   = 37'd99999999999;
    localparam int              LATENCY  = 2;
    localparam int              IDLE_PCT = 28;

    typedef struct packed {
        t_status           status;
        logic [ID_W-1:0]   id;
        logic [CNT_W-1:0]  cnt;
        logic [PRI_W-1:0]  pri;
    } t_outcome;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [MASK_W-1:0]     i_cfg_data = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = 1'b0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;

    // queue model state
    logic [ID_W-1:0]   mdl_id   [NUM_FIFOS][CLASS_DEPTH];
    logic [CNT_W-1:0]  mdl_cnt  [NUM_FIFOS][CLASS_DEPTH];
    int                mdl_head [NUM_FIFOS];
    int                mdl_fill [NUM_FIFOS];
    logic [MASK_W-1:0] mdl_mask;

    t_outcome outcome_q[$];
    int  fail_cnt = 0;
    int  words_sent = 0;
    int  words_checked = 0;
    int  status_seen [4];
    int  hold_left = 0;
    bit  calm = 1'b0;

    three_class_priority_multi_queue u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 i_clk = ~i_clk;

    initial begin
        #2_000_000;
        $display("three_class_priority_multi_queue regression: fail");
        $finish;
    end

    function automatic t_outcome predict_outcome(t_op op, logic [POINT_W-1:0] pt,
                                                 logic [PRI_W-1:0] pri, logic [ID_W-1:0] id,
                                                 logic [CNT_W-1:0] cnt);
        t_outcome r;
        int       cls;
        int       f;
        int       h;
        r = '{status: ST_OK, id: '0, cnt: '0, pri: '0};
        if (!mdl_mask[pt]) begin
            r.status = ST_CLOSED;
            return r;
        end
        if (op == OP_ENQ) begin
            // priority zero lands in class 1
            cls = (pri == 0) ? 0 : int'(pri) - 1;
            f = int'(pt) * NUM_CLASSES + cls;
            if (mdl_fill[f] >= CLASS_DEPTH) begin
                r.status = ST_FULL;
                return r;
            end
            h = (mdl_head[f] + mdl_fill[f]) % CLASS_DEPTH;
            mdl_id[f][h]  = id;
            mdl_cnt[f][h] = cnt;
            mdl_fill[f]++;
            return r;
        end
        for (cls = 0; cls < NUM_CLASSES; cls++) begin
            f = int'(pt) * NUM_CLASSES + cls;
            if (mdl_fill[f] != 0) begin
                h = mdl_head[f];
                r.id  = mdl_id[f][h];
                r.cnt = mdl_cnt[f][h];
                r.pri = PRI_W'(cls + 1);
                mdl_head[f] = (h + 1) % CLASS_DEPTH;
                mdl_fill[f]--;
                return r;
            end
        end
        r.status = ST_EMPTY;
        return r;
    endfunction

    function automatic logic [ID_W-1:0] rand_id();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return ID_W'(r % (64'(ID_MAX) + 64'd1));
    endfunction

    // sends one request word; valid stays high after acceptance unless a gap follows
    task automatic send_word(t_op op, logic [POINT_W-1:0] pt, logic [PRI_W-1:0] pri,
                             logic [ID_W-1:0] id, logic [CNT_W-1:0] cnt);
        int                   gap;
        logic [S_TDATA_W-1:0] w;
        gap = 0;
        if (!calm)
            while ($urandom_range(0, 99) < IDLE_PCT && gap < 12) gap++;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        w = '0;
        w[S_PT_LO +: POINT_W] = pt;
        w[S_PRI_LO +: PRI_W]  = pri;
        w[S_ID_LO +: ID_W]    = id;
        w[S_CNT_LO +: CNT_W]  = cnt;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        outcome_q.push_back(predict_outcome(op, pt, pri, id, cnt));
        words_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (outcome_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic write_mask(logic [MASK_W-1:0] mask);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= mask;
        do @(posedge i_clk); while (!o_cfg_ready);
        mdl_mask = mask;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_random(logic [MASK_W-1:0] mask, int enq_pct, int hot);
        logic [POINT_W-1:0] pt;
        logic [PRI_W-1:0]   pri;
        t_op                op;
        pt = POINT_W'($urandom);
        if (hot >= 0 && $urandom_range(0, 99) < 70)
            pt = POINT_W'(hot);
        else if (mask != 0 && $urandom_range(0, 99) < 85)
            while (!mask[pt]) pt = POINT_W'($urandom);
        pri = ($urandom_range(0, 99) < 8) ? 2'd0 : PRI_W'($urandom_range(1, 3));
        op  = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
        send_word(op, pt, pri, rand_id(), CNT_W'($urandom));
    endtask

    // result checker and receiver-side ready
    always @(posedge i_clk) begin
        t_outcome want;
        t_outcome got;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = '{status: t_status'(m_axis_tdata[1:0]),
                    id:     m_axis_tdata[STATUS_W +: ID_W],
                    cnt:    m_axis_tdata[STATUS_W + ID_W +: CNT_W],
                    pri:    m_axis_tdata[STATUS_W + ID_W + CNT_W +: PRI_W]};
            words_checked++;
            status_seen[got.status]++;
            if (outcome_q.size() == 0) begin
                $display("%0t: unexpected result word %0h", $time, m_axis_tdata);
                fail_cnt++;
            end else begin
                want = outcome_q.pop_front();
                if (got.status != want.status) begin
                    $display("%0t: status expected %0d actual %0d", $time, want.status,
                             got.status);
                    fail_cnt++;
                end
                if (got.id != want.id) begin
                    $display("%0t: customer id expected %0d actual %0d", $time, want.id,
                             got.id);
                    fail_cnt++;
                end
                if (got.cnt != want.cnt) begin
                    $display("%0t: item count expected %0d actual %0d", $time, want.cnt,
                             got.cnt);
                    fail_cnt++;
                end
                if (got.pri != want.pri) begin
                    $display("%0t: class expected %0d actual %0d", $time, want.pri, got.pri);
                    fail_cnt++;
                end
            end
        end
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= calm ? 1'b1 : ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    task automatic test_closed_points();
        send_word(OP_ENQ, 3'd0, 2'd1, ID_MAX, 10'h3FF);
        send_word(OP_DEQ, 3'd7, 2'd3, 37'd0, 10'd0);
    endtask

    task automatic test_priority_order();
        write_mask(8'hFF);
        send_word(OP_DEQ, 3'd3, 2'd1, ID_MAX, 10'h3FF);
        send_word(OP_ENQ, 3'd3, 2'd3, ID_MAX, 10'h3FF);
        send_word(OP_ENQ, 3'd3, 2'd2, 37'd0, 10'd0);
        send_word(OP_ENQ, 3'd3, 2'd1, 37'd1, 10'd512);
        // priority zero counts as class 1, queued behind the earlier class 1 word
        send_word(OP_ENQ, 3'd3, 2'd0, 37'h10_0000_0000, 10'd1);
        send_word(OP_ENQ, 3'd7, 2'd1, 37'd12345678901, 10'd77);
        repeat (5) send_word(OP_DEQ, 3'd3, 2'd0, 37'd0, 10'd0);
        send_word(OP_DEQ, 3'd7, 2'd2, 37'd0, 10'd0);
        send_word(OP_DEQ, 3'd7, 2'd2, 37'd0, 10'd0);
    endtask

    task automatic test_full_class();
        repeat (CLASS_DEPTH + 4) send_word(OP_ENQ, 3'd5, 2'd2, rand_id(), CNT_W'($urandom));
        send_word(OP_ENQ, 3'd5, 2'd1, rand_id(), CNT_W'($urandom));
        repeat (CLASS_DEPTH + 3) send_word(OP_DEQ, 3'd5, 2'd3, rand_id(), CNT_W'($urandom));
    endtask

    task automatic test_random_traffic();
        logic [MASK_W-1:0] masks [6];
        int                enq_pct [6];
        masks   = '{8'hFF, MASK_W'($urandom), 8'h01, 8'h80, 8'h00, MASK_W'($urandom)};
        enq_pct = '{55, 50, 75, 40, 50, 60};
        for (int ph = 0; ph < 6; ph++) begin
            write_mask(masks[ph]);
            calm = (ph == 2);
            for (int n = 0; n < ((masks[ph] == 0) ? 40 : 170); n++)
                send_random(masks[ph], enq_pct[ph], (ph == 5) ? int'($urandom_range(0, 7)) : -1);
        end
        calm = 1'b0;
    endtask

    task automatic test_backpressure();
        write_mask(8'h5A);
        hold_left = 300;
        for (int n = 0; n < 80; n++) send_random(8'h5A, 60, -1);
    endtask

    task automatic test_pause_drain();
        write_mask(MASK_W'($urandom) | 8'h01);
        for (int n = 0; n < 40; n++) send_random(mdl_mask, 65, 0);
        wait_drained();
        for (int n = 0; n < 40; n++) send_random(mdl_mask, 35, 0);
    endtask

    initial begin
        mdl_mask = '0;
        foreach (mdl_head[f]) begin
            mdl_head[f] = 0;
            mdl_fill[f] = 0;
        end
        foreach (status_seen[s]) status_seen[s] = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_closed_points();
        test_priority_order();
        test_full_class();
        test_random_traffic();
        test_backpressure();
        test_pause_drain();
        wait_drained();

        $display("covered %0d request words over several open masks, with stalls on both sides",
                 words_sent);
        $display("results checked: %0d (ok %0d, closed %0d, empty %0d, full %0d)",
                 words_checked, status_seen[ST_OK], status_seen[ST_CLOSED],
                 status_seen[ST_EMPTY], status_seen[ST_FULL]);
        if (fail_cnt == 0 && outcome_q.size() == 0) begin
            $display("three_class_priority_multi_queue regression: pass");
        end else begin
            $display("three_class_priority_multi_queue regression: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/tcpmq_pkg.sv
hw/rtl/three_class_priority_multi_queue.sv
tb/three_class_priority_multi_queue_tb.sv
